// ===== rtl/iakf_pkg.sv =====
// Shared types, constants and helper functions of the IMU tilt estimator.
package iakf_pkg;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int AVG_W   = 16;
    localparam int DPS_W   = 28;
    localparam int ANG_W   = 32;
    localparam int GAIN_W  = 17;
    localparam int LANES   = 3;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_PERIOD     = 2'd2;
    localparam logic [24:0] PROCESS_NOISE_RST     = 25'd196608;
    localparam logic [30:0] MEASUREMENT_NOISE_RST = 31'd98304000;
    localparam logic [15:0] SAMPLE_PERIOD_RST     = 16'd131;

    // Arithmetic constants
    // dps = raw * 163840 / 41 = raw * 3996 + floor(4 * raw / 41)
    localparam logic [11:0]        GYRO_INT      = 12'd3996;
    localparam logic [20:0]        GYRO_FRAC_RCP = 21'd1636804;  // 4 * ceil(2^24 / 41)
    localparam int                 GYRO_FRAC_SH  = 24;
    localparam logic signed [11:0] MEAS_SCALE = 12'sd1440;   // 90 degrees, Q3.12 -> Q16.16
    localparam logic [GAIN_W-1:0]  GAIN_ONE   = 17'd65536;
    localparam logic [1:0]         LANE_LAST  = 2'd2;

    // Serial unit sizing
    localparam int DVD_W = 34;
    localparam int DVS_W = 63;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] DIV_STEPS_GAIN = 6'd32;

    typedef enum logic [4:0] {
        ST_IDLE, ST_AVG_GO, ST_AVG_WAIT, ST_DPS_GO, ST_DPS_WAIT, ST_PRIOR,
        ST_SQ1, ST_SQ2, ST_PP_GO, ST_PP_WAIT, ST_A, ST_B, ST_S,
        ST_KDIV_GO, ST_KDIV_WAIT, ST_KSQ_GO, ST_KSQ_WAIT, ST_DIFF, ST_CORR,
        ST_EST, ST_T1, ST_T2, ST_SP_GO, ST_SP_WAIT, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_AVG_GO, OP_AVG_END, OP_DPS_GO, OP_DPS_END, OP_PRIOR,
        OP_SQ1, OP_SQ2, OP_PP_GO, OP_PP_END, OP_A, OP_B, OP_S, OP_KDIV_GO,
        OP_KSQ_GO, OP_K_END, OP_DIFF, OP_CORR, OP_EST, OP_T1, OP_T2,
        OP_SP_GO, OP_SP_END, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] lane;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic b_zero;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic signed [RAW_W-1:0] accel_x;
        logic signed [RAW_W-1:0] accel_y;
        logic signed [RAW_W-1:0] accel_z;
        logic signed [RAW_W-1:0] rate_x;
        logic signed [RAW_W-1:0] rate_y;
        logic signed [RAW_W-1:0] rate_z;
    } t_sample;

    typedef struct packed {
        logic signed [AVG_W-1:0] avg_accel_x;
        logic signed [AVG_W-1:0] avg_accel_y;
        logic signed [AVG_W-1:0] avg_accel_z;
        logic signed [DPS_W-1:0] dps_x;
        logic signed [DPS_W-1:0] dps_y;
        logic signed [DPS_W-1:0] dps_z;
        logic signed [ANG_W-1:0] tilt_angle;
        logic [GAIN_W-1:0]       blend_gain;
    } t_result;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    // Clamp a root to 2^31-1
    function automatic logic [30:0] cap31(input logic [31:0] r);
        return r[31] ? 31'h7FFFFFFF : r[30:0];
    endfunction

endpackage

// ===== rtl/iakf_ifs.sv =====
// Valid/ready channel interfaces for samples, results and configuration writes.
interface iakf_sample_if;
    import iakf_pkg::*;
    logic valid;
    logic ready;
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
    logic signed [RAW_W-1:0] rate_x;
    logic signed [RAW_W-1:0] rate_y;
    logic signed [RAW_W-1:0] rate_z;
    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  output ready);
endinterface

interface iakf_result_if;
    import iakf_pkg::*;
    logic valid;
    logic ready;
    logic signed [AVG_W-1:0] avg_accel_x;
    logic signed [AVG_W-1:0] avg_accel_y;
    logic signed [AVG_W-1:0] avg_accel_z;
    logic signed [DPS_W-1:0] dps_x;
    logic signed [DPS_W-1:0] dps_y;
    logic signed [DPS_W-1:0] dps_z;
    logic signed [ANG_W-1:0] tilt_angle;
    logic [GAIN_W-1:0]       blend_gain;
    modport source (output valid, avg_accel_x, avg_accel_y, avg_accel_z, dps_x, dps_y,
                    dps_z, tilt_angle, blend_gain, input ready);
    modport sink (input valid, avg_accel_x, avg_accel_y, avg_accel_z, dps_x, dps_y,
                  dps_z, tilt_angle, blend_gain, output ready);
endinterface

interface iakf_cfg_if;
    import iakf_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/iakf_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module iakf_div
    import iakf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVS_W-1:0] i_rem_init,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  logic [CNT_W-1:0] i_count,
    output logic [DVD_W-1:0] o_quot,
    output logic             o_done
);
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   rem2;
    logic             ge;

    // Shift in the next dividend bit and trial-subtract
    assign rem2 = {r_rem, r_dvd[DVD_W-1]};
    assign ge   = rem2 >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? DVS_W'(rem2 - {1'b0, r_dvs}) : rem2[DVS_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
endmodule

// ===== rtl/iakf_sqrt.sv =====
// Iterative integer square root of a 64-bit value, two radicand bits per cycle.
module iakf_sqrt
    import iakf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic [31:0] o_root,
    output logic        o_done
);
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_done;
    logic [63:0] trial;
    logic        busy;

    assign busy  = r_bit != 64'd0;
    assign trial = r_r + r_bit;

    // Control: the bit marker walks from 2^62 down to 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= busy && (r_bit == 64'd1);
            if (i_start) r_bit <= 64'd1 << 62;
            else if (busy) r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_r <= '0;
        end else if (busy) begin
            if (r_x >= trial) begin
                r_x <= r_x - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
        end
    end

    assign o_root = r_r[31:0];
    assign o_done = r_done;
endmodule

// ===== rtl/iakf_ctrl.sv =====
// Sequencer that steps the datapath through one filter update per beat.
module iakf_ctrl
    import iakf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);
    t_state     r_state, n_state;
    logic [1:0] r_lane, n_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            r_lane  <= n_lane;
        end
    end

    // Next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_lane     = r_lane;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.lane = r_lane;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_lane   = '0;
                    n_state  = ST_AVG_GO;
                end
            end
            ST_AVG_GO: begin
                o_cmd.op = OP_AVG_GO;
                n_state  = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                // reciprocal product registered in ST_AVG_GO is ready here
                o_cmd.op = OP_AVG_END;
                if (r_lane == LANE_LAST) begin
                    n_lane  = '0;
                    n_state = ST_DPS_GO;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = ST_AVG_GO;
                end
            end
            ST_DPS_GO: begin
                o_cmd.op = OP_DPS_GO;
                n_state  = ST_DPS_WAIT;
            end
            ST_DPS_WAIT: begin
                o_cmd.op = OP_DPS_END;
                if (r_lane == LANE_LAST) begin
                    n_lane  = '0;
                    n_state = ST_PRIOR;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = ST_DPS_GO;
                end
            end
            ST_PRIOR: begin
                o_cmd.op = OP_PRIOR;
                n_state  = ST_SQ1;
            end
            ST_SQ1: begin
                o_cmd.op = OP_SQ1;
                n_state  = ST_SQ2;
            end
            ST_SQ2: begin
                o_cmd.op = OP_SQ2;
                n_state  = ST_PP_GO;
            end
            ST_PP_GO: begin
                o_cmd.op = OP_PP_GO;
                n_state  = ST_PP_WAIT;
            end
            ST_PP_WAIT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = OP_PP_END;
                    n_state  = ST_A;
                end
            end
            ST_A: begin
                o_cmd.op = OP_A;
                n_state  = ST_B;
            end
            ST_B: begin
                o_cmd.op = OP_B;
                n_state  = ST_S;
            end
            ST_S: begin
                // zero measurement noise gives unity gain directly
                o_cmd.op = OP_S;
                n_state  = i_status.b_zero ? ST_DIFF : ST_KDIV_GO;
            end
            ST_KDIV_GO: begin
                o_cmd.op = OP_KDIV_GO;
                n_state  = ST_KDIV_WAIT;
            end
            ST_KDIV_WAIT: begin
                if (i_status.div_done) n_state = ST_KSQ_GO;
            end
            ST_KSQ_GO: begin
                o_cmd.op = OP_KSQ_GO;
                n_state  = ST_KSQ_WAIT;
            end
            ST_KSQ_WAIT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = OP_K_END;
                    n_state  = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = ST_CORR;
            end
            ST_CORR: begin
                o_cmd.op = OP_CORR;
                n_state  = ST_EST;
            end
            ST_EST: begin
                o_cmd.op = OP_EST;
                n_state  = ST_T1;
            end
            ST_T1: begin
                o_cmd.op = OP_T1;
                n_state  = ST_T2;
            end
            ST_T2: begin
                o_cmd.op = OP_T2;
                n_state  = ST_SP_GO;
            end
            ST_SP_GO: begin
                o_cmd.op = OP_SP_GO;
                n_state  = ST_SP_WAIT;
            end
            ST_SP_WAIT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = OP_SP_END;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/iakf_datapath.sv =====
// Window sums, config registers, filter arithmetic and the result register.
module iakf_datapath
    import iakf_pkg::*;
#(
    parameter int WINDOW_LEN = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_sample               i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output t_status               o_status,
    output logic                  o_out_valid,
    output t_result               o_result
);
    localparam int HIST_N = WINDOW_LEN - 1;
    localparam int SUM_W  = RAW_W + $clog2(WINDOW_LEN);

    // Reciprocal of the window length, exact for any sum magnitude below 2^SUM_W
    localparam int AVG_SH = SUM_W + $clog2(WINDOW_LEN);
    localparam int RCP_W  = SUM_W + 2;
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << AVG_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // Configuration registers
    logic [24:0] r_q_noise;
    logic [30:0] r_r_noise;
    logic [15:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_noise <= PROCESS_NOISE_RST;
            r_r_noise <= MEASUREMENT_NOISE_RST;
            r_period  <= SAMPLE_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PROCESS_NOISE:     r_q_noise <= i_cfg_data[24:0];
                CFG_MEASUREMENT_NOISE: r_r_noise <= i_cfg_data;
                CFG_SAMPLE_PERIOD:     r_period  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic signed [RAW_W-1:0] acc [LANES];
    logic signed [RAW_W-1:0] gyr [LANES];
    logic signed [SUM_W-1:0] hsum [LANES];
    logic                    load;

    assign acc[0] = i_sample.accel_x;
    assign acc[1] = i_sample.accel_y;
    assign acc[2] = i_sample.accel_z;
    assign gyr[0] = i_sample.rate_x;
    assign gyr[1] = i_sample.rate_y;
    assign gyr[2] = i_sample.rate_z;
    assign load   = i_cmd.op == OP_LOAD;

    // Sample history with a running sum of the stored taps
    generate
        if (HIST_N > 0) begin : g_hist
            logic signed [RAW_W-1:0] r_hist [LANES][HIST_N];
            logic signed [SUM_W-1:0] r_hsum [LANES];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int k = 0; k < LANES; k++) begin
                        r_hsum[k] <= '0;
                        for (int j = 0; j < HIST_N; j++) r_hist[k][j] <= '0;
                    end
                end else if (load) begin
                    for (int k = 0; k < LANES; k++) begin
                        r_hsum[k] <= r_hsum[k] + SUM_W'(acc[k]) - SUM_W'(r_hist[k][HIST_N-1]);
                        r_hist[k][0] <= acc[k];
                        for (int j = 1; j < HIST_N; j++) r_hist[k][j] <= r_hist[k][j-1];
                    end
                end
            end
            for (genvar k = 0; k < LANES; k++) begin : g_lane
                assign hsum[k] = r_hsum[k];
            end
        end else begin : g_nohist
            for (genvar k = 0; k < LANES; k++) begin : g_lane
                assign hsum[k] = '0;
            end
        end
    endgenerate

    // Working registers
    logic signed [SUM_W-1:0]  r_sum [LANES];
    logic signed [RAW_W-1:0]  r_gyr [LANES];
    logic signed [AVG_W-1:0]  r_avg [LANES];
    logic signed [DPS_W-1:0]  r_dps [LANES];
    logic signed [ANG_W-1:0]  r_prior;
    logic signed [ANG_W-1:0]  r_est;
    logic [30:0]              r_spread;
    logic [30:0]              r_pp;
    logic [61:0]              r_a;
    logic [61:0]              r_b;
    logic [62:0]              r_s;
    logic [63:0]              r_acc;
    logic [63:0]              r_prod;
    logic [GAIN_W-1:0]        r_gain;
    logic signed [32:0]       r_diff;
    logic signed [50:0]       r_corr;

    // Divider and square root operand selection
    logic [DVS_W-1:0] div_rem;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic [CNT_W-1:0] div_cnt;
    logic [DVD_W-1:0] div_q;
    logic             div_start, div_done;
    logic [63:0]      sq_x;
    logic [31:0]      sq_root;
    logic             sq_start, sq_done;
    logic [SUM_W-1:0] sum_mag;
    logic [RAW_W-1:0] gyr_mag;
    logic             sum_neg, gyr_neg;

    assign sum_neg = r_sum[i_cmd.lane][SUM_W-1];
    assign gyr_neg = r_gyr[i_cmd.lane][RAW_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-r_sum[i_cmd.lane]) : SUM_W'(r_sum[i_cmd.lane]);
    assign gyr_mag = gyr_neg ? RAW_W'(-r_gyr[i_cmd.lane]) : RAW_W'(r_gyr[i_cmd.lane]);

    // The divider only forms the gain ratio a * 2^32 / (a + b)
    assign div_start = i_cmd.op == OP_KDIV_GO;
    assign div_rem   = DVS_W'(r_a);
    assign div_dvd   = '0;
    assign div_dvs   = r_s;
    assign div_cnt   = DIV_STEPS_GAIN;

    always_comb begin
        sq_start = 1'b0;
        sq_x     = r_acc;
        case (i_cmd.op)
            OP_PP_GO, OP_SP_GO: sq_start = 1'b1;
            OP_KSQ_GO: begin
                sq_start = 1'b1;
                sq_x     = 64'(div_q);
            end
            default: ;
        endcase
    end

    iakf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (div_rem),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_count    (div_cnt),
        .o_quot     (div_q),
        .o_done     (div_done)
    );

    iakf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_root  (sq_root),
        .o_done  (sq_done)
    );

    // One arithmetic step per command
    logic signed [28:0]       neg_dx;
    logic signed [45:0]       drift;
    logic signed [27:0]       meas;
    logic [GAIN_W-1:0]        m;
    logic [63:0]              avg_mag;
    logic signed [AVG_W-1:0]  avg_q;
    logic signed [DPS_W-1:0]  dps_q;

    assign neg_dx  = -29'(r_dps[0]);
    assign drift   = neg_dx * $signed({1'b0, r_period});
    assign meas    = r_avg[0] * MEAS_SCALE;
    assign m       = GAIN_ONE - r_gain;
    assign avg_mag = r_prod >> AVG_SH;
    assign avg_q   = sum_neg ? AVG_W'(-avg_mag) : AVG_W'(avg_mag);
    assign dps_q   = gyr_neg ? DPS_W'(-r_prod) : DPS_W'(r_prod);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int k = 0; k < LANES; k++) begin
                    r_sum[k] <= SUM_W'(acc[k]) + hsum[k];
                    r_gyr[k] <= gyr[k];
                end
            end
            OP_AVG_GO:  r_prod <= 64'(sum_mag * AVG_RCP);
            OP_AVG_END: r_avg[i_cmd.lane] <= avg_q;
            OP_DPS_GO:  r_prod <= 64'(gyr_mag * GYRO_INT)
                                  + 64'((gyr_mag * GYRO_FRAC_RCP) >> GYRO_FRAC_SH);
            OP_DPS_END: r_dps[i_cmd.lane] <= dps_q;
            OP_PRIOR:   r_prior <= sat32(36'(r_est) + 36'(drift >>> 16));
            OP_SQ1:     r_acc <= 64'(r_spread * r_spread);
            OP_SQ2:     r_acc <= r_acc + 64'(r_q_noise * r_q_noise);
            OP_PP_END:  r_pp <= cap31(sq_root);
            OP_A:       r_a <= r_pp * r_pp;
            OP_B:       r_b <= r_r_noise * r_r_noise;
            OP_S: begin
                r_s <= 63'(r_a) + 63'(r_b);
                if (r_b == '0) r_gain <= GAIN_ONE;
            end
            OP_K_END:   r_gain <= GAIN_W'(sq_root);
            OP_DIFF:    r_diff <= 33'(meas) - 33'(r_prior);
            OP_CORR:    r_corr <= $signed({1'b0, r_gain}) * r_diff;
            OP_T1:      r_acc <= 64'(r_a[61:16] * m);
            OP_T2:      r_acc <= r_acc + 64'((r_a[15:0] * m) >> 16);
            default: ;
        endcase
    end

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est    <= '0;
            r_spread <= '0;
        end else begin
            if (i_cmd.op == OP_EST) r_est <= sat32(36'(r_prior) + 36'(r_corr >>> 16));
            if (i_cmd.op == OP_SP_END) r_spread <= cap31(sq_root);
        end
    end

    // Result register, loaded only when empty or being drained
    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.op == OP_OUT) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_out.avg_accel_x <= r_avg[0];
            r_out.avg_accel_y <= r_avg[1];
            r_out.avg_accel_z <= r_avg[2];
            r_out.dps_x       <= r_dps[0];
            r_out.dps_y       <= r_dps[1];
            r_out.dps_z       <= r_dps[2];
            r_out.tilt_angle  <= r_est;
            r_out.blend_gain  <= r_gain;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result           = r_out;
    assign o_status.div_done  = div_done;
    assign o_status.sqrt_done = sq_done;
    assign o_status.b_zero    = r_b == '0;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
endmodule

// ===== rtl/imu_average_kalman_angle_unit.sv =====
// Top level of the IMU tilt estimator: window average, gyro scaling, angle filter.
// Each sample beat is processed to completion before the next one is accepted; an update
// is dominated by the 32-step square roots (three, or two with zero R) and the 32-step
// gain division (skipped with zero R); averages and dps use a start and an end state.
// A waiting result does not block the next sample beat; the next result holds in the
// last step until the result register drains.
// Reset (i_rst_n low, synchronous) zeroes the windows, estimate and spread, and
// loads the default noise and period registers.
module imu_average_kalman_angle_unit
    import iakf_pkg::*;
#(
    parameter int WINDOW_LEN = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    iakf_sample_if.sink   i_sample,
    iakf_cfg_if.sink      i_cfg,
    iakf_result_if.source o_result
);
    t_cmd    cmd;
    t_status status;
    t_sample sample;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    assign sample.accel_x = i_sample.accel_x;
    assign sample.accel_y = i_sample.accel_y;
    assign sample.accel_z = i_sample.accel_z;
    assign sample.rate_x  = i_sample.rate_x;
    assign sample.rate_y  = i_sample.rate_y;
    assign sample.rate_z  = i_sample.rate_z;
    assign i_sample.ready = in_ready;
    assign i_cfg.ready    = 1'b1;

    iakf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    iakf_datapath #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (sample),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_addr  (i_cfg.addr),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign o_result.valid       = out_valid;
    assign o_result.avg_accel_x = result.avg_accel_x;
    assign o_result.avg_accel_y = result.avg_accel_y;
    assign o_result.avg_accel_z = result.avg_accel_z;
    assign o_result.dps_x       = result.dps_x;
    assign o_result.dps_y       = result.dps_y;
    assign o_result.dps_z       = result.dps_z;
    assign o_result.tilt_angle  = result.tilt_angle;
    assign o_result.blend_gain  = result.blend_gain;

    // An accepted beat keeps the input closed while it is processed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.valid && in_ready |=> !in_ready)
        else $error("sample accepted while previous beat in progress");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_OUT |-> !out_valid || o_result.ready)
        else $error("result register overwritten");

    // The gain never exceeds one
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> result.blend_gain <= GAIN_ONE)
        else $error("gain above unity");

    // Divider and root units never finish in the same cycle
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.div_done && status.sqrt_done))
        else $error("divider and square root overlap");
endmodule
